### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// They use the clock clk_i and the active-low reset rst_ni of the module that expands them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge while out of reset.
`define STBS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("snapshot sampler assertion failed");

// The expression must never be true while out of reset.
`define STBS_ASSERT_NEVER(lbl, expr) `STBS_ASSERT(lbl, !(expr))

`endif

### hw/rtl/stbs_pkg.sv
// Shared types and constants of the snapshot time bar sampler.
// Used by the front, queue, back, top level and checker modules.
package stbs_pkg;

  localparam int TABLE_SLOTS = 1024;
  localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

  localparam int TIME_W    = 28;
  localparam int CODE_W    = 20;
  localparam int OTIME_W   = 57;
  localparam int TAG_W     = 32;
  localparam int FSLOT_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int TOD_W     = 30;

  localparam logic [CFG_IDX_W-1:0] REG_AM_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AM_END    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PM_START  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PM_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE = 3'd4;

  localparam logic [1:0] STEP_30S  = 2'd0;
  localparam logic [1:0] STEP_60S  = 2'd1;
  localparam logic [1:0] STEP_300S = 2'd2;

  localparam logic KIND_SNAP  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;
  localparam logic STAT_BAR   = 1'b0;
  localparam logic STAT_FULL  = 1'b1;

  // Largest bar end the grid can produce (15:05:00.000).
  localparam logic [TIME_W-1:0] BAR_MAX = 28'd150500000;

  typedef struct packed {
    logic               kind;
    logic [CODE_W-1:0]  security_code;
    logic [OTIME_W-1:0] orig_time;
    logic [TAG_W-1:0]   snapshot_tag;
    logic [FSLOT_W-1:0] flush_slot;
  } in_req_t;

  typedef struct packed {
    logic              status;
    logic [TIME_W-1:0] bar_time;
    logic [CODE_W-1:0] bar_code;
    logic [TAG_W-1:0]  bar_tag;
  } out_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] am_start;
    logic [TIME_W-1:0] am_end;
    logic [TIME_W-1:0] pm_start;
    logic [TIME_W-1:0] pm_end;
    logic [1:0]        step_mode;
  } cfg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic               kind;
    logic [CODE_W-1:0]  code;
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  bar;
    logic [FSLOT_W-1:0] slot;
  } item_t;

  // One table row.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] bar;
    logic [TAG_W-1:0]  tag;
  } row_t;

endpackage

### hw/rtl/snapshot_time_bar_sampler.sv
// Top level of the snapshot time bar sampler: configuration registers, front, queue, back.
// Depends on stbs_pkg, stbs_front, stbs_fifo and stbs_back.
//
// Usage: requests enter on in_valid_i / in_stall_o / in_req_i and are taken at a
// rising edge with in_valid_i high and in_stall_o low. Results leave on out_valid_o /
// out_stall_i / out_req_o under the same rule. Configuration is written through
// cfg_we_i, cfg_idx_i and cfg_data_i while the block is idle.
// A snapshot keeps in_stall_o high while divisions, each through an estimate, remainder
// and correction state, reduce the timestamp to the time of day and split out hours,
// minutes and seconds by reciprocal multiplication; a classify state and a push state
// then hand it to the queue. A snapshot outside the sessions is dropped at the classify
// state, and a flush goes straight to the push state. The front stays stalled longer
// while the queue is full. The back scans the table one slot per cycle. A result
// passes from the result holder to the output register, which must be free first,
// before it shows on out_valid_o.
// Reset empties the table and loads the default sessions and one-minute grid; no
// clearing pass is needed. While the receiver stalls, the result stays in the output
// register, the back waits, the queue fills and then the front stops accepting.
module snapshot_time_bar_sampler import stbs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TIME_W-1:0]    cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_req_t              in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_req_t             out_req_o
);

  cfg_t  cfg_q, cfg_d;
  logic  push, full, pop, empty;
  item_t push_item, pop_item;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AM_START:  cfg_d.am_start  = cfg_data_i;
        REG_AM_END:    cfg_d.am_end    = cfg_data_i;
        REG_PM_START:  cfg_d.pm_start  = cfg_data_i;
        REG_PM_END:    cfg_d.pm_end    = cfg_data_i;
        REG_STEP_MODE: cfg_d.step_mode = cfg_data_i[1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{am_start: 28'd93000000, am_end: 28'd113000000,
                 pm_start: 28'd130000000, pm_end: 28'd150000000, step_mode: STEP_60S};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  stbs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  stbs_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .empty_o     (empty)
  );

  stbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .pop_item_i  (pop_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

endmodule

### hw/rtl/stbs_fifo.sv
// Two-entry queue of classified requests between the front and the back.
// Depends on stbs_pkg for the item type.
module stbs_fifo import stbs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  empty_o
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !full_o) begin
      wr_ptr_d = ~wr_ptr_q;
      cnt_d    = cnt_d + 2'd1;
    end
    if (pop_i && !empty_o) begin
      rd_ptr_d = ~rd_ptr_q;
      cnt_d    = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hw/rtl/stbs_front.sv
// Front part: accepts requests, reduces the timestamp to the time of day,
// splits it into hours, minutes and seconds, filters by session and finds the bar end.
// Depends on stbs_pkg.
module stbs_front import stbs_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  in_req_t in_req_i,
  output logic    push_o,
  output item_t   push_item_o,
  input  logic    full_i
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_EST   = 3'd1;
  localparam logic [2:0] F_REM   = 3'd2;
  localparam logic [2:0] F_FIX   = 3'd3;
  localparam logic [2:0] F_CLASS = 3'd4;
  localparam logic [2:0] F_PUSH  = 3'd5;

  localparam logic [1:0] PH_DAY = 2'd0;
  localparam logic [1:0] PH_HR  = 2'd1;
  localparam logic [1:0] PH_MIN = 2'd2;
  localparam logic [1:0] PH_SEC = 2'd3;

  // Reciprocals rounded down: 2^59 / 1e9 for the day, 2^32 / divisor for the digit pairs.
  // Each estimate is at most one below the true quotient, so one correction step suffices.
  localparam logic [29:0] RC_DAY = 30'd576460752;
  localparam logic [22:0] RC_HR  = 23'd429;
  localparam logic [22:0] RC_MIN = 23'd42949;
  localparam logic [22:0] RC_SEC = 23'd4294967;

  localparam logic [TOD_W-1:0] D_DAY = 30'd1000000000;
  localparam logic [TOD_W-1:0] D_HR  = 30'd10000000;
  localparam logic [TOD_W-1:0] D_MIN = 30'd100000;
  localparam logic [TOD_W-1:0] D_SEC = 30'd1000;

  localparam logic [TOD_W-1:0] T0930    = 30'd93000000;
  localparam logic [TOD_W-1:0] T1300    = 30'd130000000;
  localparam logic [TOD_W-1:0] AM_LAST1 = 30'd113100000;
  localparam logic [TOD_W-1:0] AM_LAST5 = 30'd113500000;
  localparam logic [TOD_W-1:0] PM_LAST1 = 30'd150100000;
  localparam logic [TOD_W-1:0] PM_LAST5 = 30'd150500000;

  logic [2:0]         st_q, st_d;
  logic [1:0]         ph_q, ph_d;
  logic [OTIME_W-1:0] x_q, x_d;
  logic [TOD_W-1:0]   val_q, val_d;
  logic [27:0]        est_q, est_d;
  logic [30:0]        rem_q, rem_d;
  logic [TOD_W-1:0]   tod_q, tod_d;
  logic [6:0]         hh_q, hh_d, mm_q, mm_d, ss_q, ss_d;
  item_t              it_q, it_d;

  logic [22:0]        rc;
  logic [TOD_W-1:0]   dsel;
  logic [27:0]        est;
  logic [30:0]        prod_back, rem_base, rem, rem_fix;
  logic               ge;
  logic [6:0]         dig;

  logic               in_sess;
  logic [6:0]         nh, nm, ns;
  logic [TOD_W-1:0]   nxt, am_last, pm_last;
  logic [TIME_W-1:0]  bar;

  // First multiple of five minutes strictly above m, for m below 60.
  function automatic logic [6:0] next_five(input logic [6:0] m);
    logic [6:0] r;
    r = 7'd5;
    for (int i = 1; i < 12; i++) begin
      if (m >= 7'(5 * i)) r = 7'(5 * (i + 1));
    end
    return r;
  endfunction

  assign in_stall_o  = (st_q != F_IDLE);
  assign push_o      = (st_q == F_PUSH) && !full_i;
  assign push_item_o = it_q;

  // Bar end from the split time of day. Minutes or seconds above 59 order after the
  // whole minute or hour, so they roll over to the next one.
  always_comb begin
    nh = hh_q;
    nm = mm_q;
    ns = 7'd0;
    if (mm_q >= 7'd60) begin
      nh = hh_q + 7'd1;
      nm = 7'd0;
    end else begin
      case (cfg_i.step_mode)
        STEP_30S: begin
          if (ss_q < 7'd30) ns = 7'd30;
          else nm = mm_q + 7'd1;
        end
        STEP_300S: nm = next_five(mm_q);
        default:   nm = mm_q + 7'd1;
      endcase
      if (nm == 7'd60) begin
        nh = hh_q + 7'd1;
        nm = 7'd0;
      end
    end
    nxt = TOD_W'(32'(nh) * 32'd10000000 + 32'(nm) * 32'd100000 + 32'(ns) * 32'd1000);

    if (cfg_i.step_mode == STEP_300S) begin
      am_last = AM_LAST5;
      pm_last = PM_LAST5;
    end else begin
      am_last = AM_LAST1;
      pm_last = PM_LAST1;
    end

    if (tod_q < T0930) bar = TIME_W'(T0930);
    else if (tod_q < am_last) bar = TIME_W'(nxt);
    else if (tod_q < T1300) bar = TIME_W'(T1300);
    else if (tod_q < pm_last) bar = TIME_W'(nxt);
    else bar = '0;

    in_sess = (tod_q >= TOD_W'(cfg_i.am_start) && tod_q < TOD_W'(cfg_i.am_end)) ||
              (tod_q >= TOD_W'(cfg_i.pm_start) && tod_q < TOD_W'(cfg_i.pm_end));
  end

  // Divide by a constant through the estimate, remainder and correction states.
  always_comb begin
    unique case (ph_q)
      PH_HR: begin
        rc   = RC_HR;
        dsel = D_HR;
      end
      PH_MIN: begin
        rc   = RC_MIN;
        dsel = D_MIN;
      end
      PH_SEC: begin
        rc   = RC_SEC;
        dsel = D_SEC;
      end
      default: begin
        rc   = RC_HR;
        dsel = D_DAY;
      end
    endcase
    est = (ph_q == PH_DAY) ? 28'((60'(x_q[OTIME_W-1:27]) * 60'(RC_DAY)) >> 32)
                           : 28'((53'(val_q) * 53'(rc)) >> 32);
    // The remainder is below twice the divisor, so the low 31 bits are exact.
    prod_back = 31'(58'(est_q) * 58'(dsel));
    rem_base  = (ph_q == PH_DAY) ? x_q[30:0] : 31'(val_q);
    rem       = rem_base - prod_back;
    ge        = (rem_q >= 31'(dsel));
    rem_fix   = ge ? rem_q - 31'(dsel) : rem_q;
    dig       = est_q[6:0] + 7'(ge);
  end

  always_comb begin
    st_d  = st_q;
    ph_d  = ph_q;
    x_d   = x_q;
    val_d = val_q;
    est_d = est_q;
    rem_d = rem_q;
    tod_d = tod_q;
    hh_d  = hh_q;
    mm_d  = mm_q;
    ss_d  = ss_q;
    it_d  = it_q;

    unique case (st_q)
      F_IDLE: begin
        if (in_valid_i) begin
          it_d.kind = in_req_i.kind;
          it_d.code = in_req_i.security_code;
          it_d.tag  = in_req_i.snapshot_tag;
          it_d.slot = in_req_i.flush_slot;
          it_d.bar  = '0;
          x_d       = in_req_i.orig_time;
          ph_d      = PH_DAY;
          st_d      = (in_req_i.kind == KIND_FLUSH) ? F_PUSH : F_EST;
        end
      end
      F_EST: begin
        est_d = est;
        st_d  = F_REM;
      end
      F_REM: begin
        rem_d = rem;
        st_d  = F_FIX;
      end
      F_FIX: begin
        val_d = rem_fix[TOD_W-1:0];
        st_d  = F_EST;
        unique case (ph_q)
          PH_DAY: begin
            tod_d = rem_fix[TOD_W-1:0];
            ph_d  = PH_HR;
          end
          PH_HR: begin
            hh_d = dig;
            ph_d = PH_MIN;
          end
          PH_MIN: begin
            mm_d = dig;
            ph_d = PH_SEC;
          end
          default: begin
            ss_d = dig;
            st_d = F_CLASS;
          end
        endcase
      end
      F_CLASS: begin
        it_d.bar = bar;
        st_d     = in_sess ? F_PUSH : F_IDLE;
      end
      F_PUSH: begin
        if (!full_i) st_d = F_IDLE;
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ph_q  <= ph_d;
    x_q   <= x_d;
    val_q <= val_d;
    est_q <= est_d;
    rem_q <= rem_d;
    tod_q <= tod_d;
    hh_q  <= hh_d;
    mm_q  <= mm_d;
    ss_q  <= ss_d;
    it_q  <= it_d;
  end

endmodule

### hw/rtl/stbs_back.sv
// Back part: owns the per-code table memory, scans it for the code, updates rows
// and drives the registered result channel.
// Depends on stbs_pkg.
module stbs_back import stbs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     empty_i,
  input  item_t    pop_item_i,
  output logic     pop_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_req_t out_req_o
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_FOUT = 3'd1;
  localparam logic [2:0] B_SCAN = 3'd2;
  localparam logic [2:0] B_UPD  = 3'd3;
  localparam logic [2:0] B_EMIT = 3'd4;

  row_t              mem [TABLE_SLOTS];
  row_t              rdata_q;
  logic              mem_re, mem_we;
  logic [SLOT_W-1:0] mem_raddr, mem_waddr;
  row_t              mem_wdata;

  logic [2:0]        st_q, st_d;
  item_t             it_q, it_d;
  logic [CNT_W-1:0]  iss_q, iss_d, used_q, used_d;
  logic              pend_q, pend_d;
  logic [SLOT_W-1:0] pidx_q, pidx_d;
  out_req_t          res_q, res_d;
  logic              ov_q, ov_d;
  out_req_t          out_q, out_d;
  logic              hit;

  assign out_valid_o = ov_q;
  assign out_req_o   = out_q;
  assign pop_o       = (st_q == B_IDLE) && !empty_i;
  assign hit         = pend_q && (rdata_q.code == it_q.code);

  // Slots are filled in order and never freed, so a slot is valid when below the fill count.
  always_comb begin
    st_d      = st_q;
    it_d      = it_q;
    iss_d     = iss_q;
    used_d    = used_q;
    pend_d    = pend_q;
    pidx_d    = pidx_q;
    res_d     = res_q;
    mem_re    = 1'b0;
    mem_raddr = iss_q[SLOT_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = pidx_q;
    mem_wdata = rdata_q;

    unique case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          it_d = pop_item_i;
          if (pop_item_i.kind == KIND_FLUSH) begin
            if (17'(pop_item_i.slot) < 17'(TABLE_SLOTS) &&
                17'(pop_item_i.slot) < 17'(used_q)) begin
              mem_re    = 1'b1;
              mem_raddr = SLOT_W'(pop_item_i.slot);
              st_d      = B_FOUT;
            end
          end else begin
            iss_d  = '0;
            pend_d = 1'b0;
            st_d   = B_SCAN;
          end
        end
      end
      B_FOUT: begin
        res_d = '{status: STAT_BAR, bar_time: rdata_q.bar, bar_code: rdata_q.code,
                  bar_tag: rdata_q.tag};
        st_d  = B_EMIT;
      end
      B_SCAN: begin
        if (hit) begin
          st_d = B_UPD;
        end else if (iss_q < used_q) begin
          mem_re    = 1'b1;
          mem_raddr = iss_q[SLOT_W-1:0];
          pend_d    = 1'b1;
          pidx_d    = iss_q[SLOT_W-1:0];
          iss_d     = iss_q + CNT_W'(1);
        end else if (used_q == CNT_W'(TABLE_SLOTS)) begin
          res_d = '{status: STAT_FULL, bar_time: '0, bar_code: it_q.code, bar_tag: it_q.tag};
          st_d  = B_EMIT;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = used_q[SLOT_W-1:0];
          mem_wdata = '{code: it_q.code, bar: it_q.bar, tag: it_q.tag};
          used_d    = used_q + CNT_W'(1);
          st_d      = B_IDLE;
        end
      end
      B_UPD: begin
        mem_we = 1'b1;
        if (it_q.bar != rdata_q.bar) begin
          res_d     = '{status: STAT_BAR, bar_time: rdata_q.bar, bar_code: rdata_q.code,
                        bar_tag: rdata_q.tag};
          mem_wdata = '{code: rdata_q.code, bar: it_q.bar, tag: it_q.tag};
          st_d      = B_EMIT;
        end else begin
          mem_wdata = '{code: rdata_q.code, bar: rdata_q.bar, tag: it_q.tag};
          st_d      = B_IDLE;
        end
      end
      B_EMIT: begin
        if (!ov_q || !out_stall_i) st_d = B_IDLE;
      end
      default: st_d = B_IDLE;
    endcase
  end

  // Output register: loaded from the result holder once the slot is free or being taken.
  always_comb begin
    ov_d  = ov_q;
    out_d = out_q;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    if (st_q == B_EMIT && (!ov_q || !out_stall_i)) begin
      ov_d  = 1'b1;
      out_d = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= B_IDLE;
      used_q <= '0;
      ov_q   <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      used_q <= used_d;
      ov_q   <= ov_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    it_q   <= it_d;
    iss_q  <= iss_d;
    pidx_q <= pidx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

endmodule

### hw/rtl/stbs_checker.sv
// Port-level checker of the snapshot time bar sampler, bound to the top level.
// Depends on stbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module stbs_checker import stbs_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [TIME_W-1:0]    cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input in_req_t              in_req_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input out_req_t             out_req_o
);

  // A held result does not change until it is taken.
  `STBS_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_req_o))

  // The front works on one request at a time, so it stalls right after taking one.
  `STBS_ASSERT(a_busy_after_accept, in_valid_i && !in_stall_o |=> in_stall_o)

  // A table-full report carries no bar time.
  `STBS_ASSERT_NEVER(a_full_no_bar,
    out_valid_o && out_req_o.status == STAT_FULL && out_req_o.bar_time != '0)

  // Bar times only come from the grid.
  `STBS_ASSERT_NEVER(a_bar_range, out_valid_o && out_req_o.bar_time > BAR_MAX)

endmodule

bind snapshot_time_bar_sampler stbs_checker u_stbs_checker (.*);

### tb/tb_snapshot_time_bar_sampler.sv
// Self-checking testbench of the snapshot time bar sampler: random and directed
// snapshots and flushes against a predictor of the per-code bar table.
// Depends on stbs_pkg and snapshot_time_bar_sampler.
module tb_snapshot_time_bar_sampler;
  import stbs_pkg::*;

  localparam int IDLE_WAIT = 5000;
  localparam int WATCHDOG  = 40000;
  localparam int POOL_N    = 20;

  typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_e;
  typedef struct {
    op_kind_e             kind;
    in_req_t              req;
    logic [CFG_IDX_W-1:0] idx;
    logic [TIME_W-1:0]    data;
  } op_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [TIME_W-1:0]    cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_req_t              in_req_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_req_t             out_req_o;

  snapshot_time_bar_sampler i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  op_t      pending_ops[$];
  out_req_t bar_records[$];
  int       errors = 0;
  int       idle_cnt = 0;
  int       quiet_cnt = 0;
  bit       timed_out = 1'b0;
  bit       all_done = 1'b0;
  int       pool[POOL_N];

  // Predictor copy of the configuration and the table.
  cfg_t             cfg_model;
  bit               row_valid[TABLE_SLOTS];
  logic [CODE_W-1:0] row_code[TABLE_SLOTS];
  logic [TIME_W-1:0] row_bar[TABLE_SLOTS];
  logic [TAG_W-1:0]  row_tag[TABLE_SLOTS];
  int               rows_used = 0;

  function automatic logic [TIME_W-1:0] sec_to_clock(int unsigned s);
    int unsigned h, m;
    h = s / 3600;
    m = (s - h * 3600) / 60;
    return TIME_W'(h * 10000000 + m * 100000 + (s - h * 3600 - m * 60) * 1000);
  endfunction

  function automatic logic [TIME_W-1:0] grid_bar_end(longint unsigned tod, logic [1:0] mode);
    int unsigned step, am_last, pm_last, s;
    step = (mode == STEP_30S) ? 30 : (mode == STEP_300S) ? 300 : 60;
    am_last = (step == 300) ? 11 * 3600 + 35 * 60 : 11 * 3600 + 31 * 60;
    pm_last = (step == 300) ? 15 * 3600 + 5 * 60 : 15 * 3600 + 60;
    for (s = 9 * 3600 + 30 * 60; s <= am_last; s += step)
      if (tod < sec_to_clock(s)) return sec_to_clock(s);
    for (s = 13 * 3600; s <= pm_last; s += step)
      if (tod < sec_to_clock(s)) return sec_to_clock(s);
    return '0;
  endfunction

  task automatic predict_request(in_req_t r);
    longint unsigned tod;
    logic [TIME_W-1:0] bar;
    int slot;
    out_req_t rec;
    slot = -1;
    if (r.kind == KIND_FLUSH) begin
      if (row_valid[r.flush_slot]) begin
        rec = '{STAT_BAR, row_bar[r.flush_slot], row_code[r.flush_slot], row_tag[r.flush_slot]};
        bar_records = {bar_records, rec};
      end
      return;
    end
    tod = longint'(r.orig_time) % 64'd1000000000;
    if (!((tod >= cfg_model.am_start && tod < cfg_model.am_end) ||
          (tod >= cfg_model.pm_start && tod < cfg_model.pm_end))) return;
    bar = grid_bar_end(tod, cfg_model.step_mode);
    for (int i = 0; i < rows_used; i++)
      if (row_valid[i] && row_code[i] == r.security_code) begin
        slot = i;
        break;
      end
    if (slot < 0) begin
      if (rows_used >= TABLE_SLOTS) begin
        rec = '{STAT_FULL, '0, r.security_code, r.snapshot_tag};
        bar_records = {bar_records, rec};
      end else begin
        row_valid[rows_used] = 1'b1;
        row_code[rows_used]  = r.security_code;
        row_bar[rows_used]   = bar;
        row_tag[rows_used]   = r.snapshot_tag;
        rows_used++;
      end
      return;
    end
    if (bar != row_bar[slot]) begin
      rec = '{STAT_BAR, row_bar[slot], row_code[slot], row_tag[slot]};
      bar_records = {bar_records, rec};
      row_bar[slot] = bar;
    end
    row_tag[slot] = r.snapshot_tag;
  endtask

  // Sender: bursts of requests with random gaps; configuration only when idle.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin : driver
    bit      acc;
    bit      nxt_valid, nxt_we;
    in_req_t nxt_req;
    op_t     nxt_op;
    if (rst_ni) begin
      acc = in_valid_i && !in_stall_o;
      if (acc) predict_request(in_req_i);
      nxt_valid = in_valid_i && !acc;
      nxt_req = in_req_i;
      nxt_we = 1'b0;
      if (!nxt_valid && pending_ops.size() > 0) begin
        case (pending_ops[0].kind)
          OP_ITEM: begin
            if (gap_left > 0) begin
              gap_left--;
            end else begin
              nxt_valid = 1'b1;
              nxt_op = pending_ops.pop_front();
              nxt_req = nxt_op.req;
              if (burst_left > 0) begin
                burst_left--;
              end else begin
                burst_left = $urandom_range(0, 40);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
              end
            end
          end
          OP_CFG: begin
            if (!in_valid_i && bar_records.size() == 0 && idle_cnt >= IDLE_WAIT) begin
              nxt_we = 1'b1;
              cfg_idx_i <= pending_ops[0].idx;
              cfg_data_i <= pending_ops[0].data;
              case (pending_ops[0].idx)
                REG_AM_START:  cfg_model.am_start = pending_ops[0].data;
                REG_AM_END:    cfg_model.am_end = pending_ops[0].data;
                REG_PM_START:  cfg_model.pm_start = pending_ops[0].data;
                REG_PM_END:    cfg_model.pm_end = pending_ops[0].data;
                REG_STEP_MODE: cfg_model.step_mode = pending_ops[0].data[1:0];
                default: ;
              endcase
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (bar_records.size() == 0) void'(pending_ops.pop_front());
          end
        endcase
      end
      in_valid_i <= nxt_valid;
      in_req_i <= nxt_req;
      cfg_we_i <= nxt_we;
    end
  end

  // Receiver with its own stall pattern, result check and watchdog.
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin : monitor
    bit       got, in_acc;
    out_req_t want;
    if (rst_ni) begin
      got = out_valid_o && !out_stall_i;
      in_acc = in_valid_i && !in_stall_o;
      if (got) begin
        if (bar_records.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %p", $time, out_req_o);
        end else begin
          want = bar_records.pop_front();
          if (out_req_o.status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_req_o.status);
          end
          if (out_req_o.bar_time !== want.bar_time) begin
            errors++;
            $display("%0t: bar_time expected %0d actual %0d", $time, want.bar_time,
                     out_req_o.bar_time);
          end
          if (out_req_o.bar_code !== want.bar_code) begin
            errors++;
            $display("%0t: bar_code expected %0d actual %0d", $time, want.bar_code,
                     out_req_o.bar_code);
          end
          if (out_req_o.bar_tag !== want.bar_tag) begin
            errors++;
            $display("%0t: bar_tag expected %0h actual %0h", $time, want.bar_tag,
                     out_req_o.bar_tag);
          end
        end
      end
      idle_cnt = (got || in_acc || in_valid_i || bar_records.size() != 0) ? 0 : idle_cnt + 1;
      quiet_cnt = (got || in_acc || cfg_we_i) ? 0 : quiet_cnt + 1;
      if (quiet_cnt >= WATCHDOG) timed_out = 1'b1;
      if (pending_ops.size() == 0 && !in_valid_i && idle_cnt >= IDLE_WAIT) all_done = 1'b1;
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(64, 512);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 1) == 1);
        default: out_stall_i <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic in_req_t snap_req(int unsigned code, longint unsigned tod,
                                       logic [TAG_W-1:0] tag);
    in_req_t r;
    r = '0;
    r.kind = KIND_SNAP;
    r.security_code = CODE_W'(code);
    r.snapshot_tag = tag;
    r.flush_slot = FSLOT_W'($urandom_range(0, 1023));
    if ($urandom_range(0, 19) == 0)
      r.orig_time = OTIME_W'({$urandom, $urandom});
    else
      r.orig_time = OTIME_W'(longint'($urandom_range(0, 99991231)) * 64'd1000000000 + tod);
    return r;
  endfunction

  function automatic in_req_t flush_req(int unsigned slot);
    in_req_t r;
    r.kind = KIND_FLUSH;
    r.security_code = CODE_W'($urandom);
    r.orig_time = OTIME_W'({$urandom, $urandom});
    r.snapshot_tag = $urandom;
    r.flush_slot = FSLOT_W'(slot);
    return r;
  endfunction

  function automatic longint unsigned rand_tod();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 6)
      return $urandom_range(9, 15) * 10000000 + $urandom_range(0, 59) * 100000 +
             $urandom_range(0, 59999);
    if (pick < 8)
      return sec_to_clock($urandom_range(9 * 3600 + 1700, 15 * 3600 + 400) / 30 * 30) +
             $urandom_range(0, 1) - $urandom_range(0, 1);
    return $urandom_range(0, 999999999);
  endfunction

  task automatic push_req(in_req_t r);
    op_t o;
    o.kind = OP_ITEM;
    o.req = r;
    o.idx = '0;
    o.data = '0;
    pending_ops = {pending_ops, o};
  endtask

  task automatic push_cfg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] data);
    op_t o;
    o.kind = OP_CFG;
    o.req = '0;
    o.idx = idx;
    o.data = data;
    pending_ops = {pending_ops, o};
  endtask

  task automatic push_drain();
    op_t o;
    o.kind = OP_DRAIN;
    o.req = '0;
    o.idx = '0;
    o.data = '0;
    pending_ops = {pending_ops, o};
  endtask

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) push_drain();
      if ($urandom_range(0, 6) == 0)
        push_req(flush_req(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                       : $urandom_range(0, 31)));
      else
        push_req(snap_req(pool[$urandom_range(0, POOL_N - 1)], rand_tod(), $urandom));
    end
  endtask

  task automatic set_sessions(int unsigned a0, int unsigned a1, int unsigned p0,
                              int unsigned p1, logic [1:0] mode);
    push_cfg(REG_AM_START, TIME_W'(a0));
    push_cfg(REG_AM_END, TIME_W'(a1));
    push_cfg(REG_PM_START, TIME_W'(p0));
    push_cfg(REG_PM_END, TIME_W'(p1));
    push_cfg(REG_STEP_MODE, TIME_W'(mode));
  endtask

  initial begin
    cfg_model = '{28'd93000000, 28'd113000000, 28'd130000000, 28'd150000000, STEP_60S};
    foreach (row_valid[i]) row_valid[i] = 1'b0;
    foreach (pool[i]) pool[i] = $urandom_range(0, 499999);
    pool[0] = 0;
    pool[1] = 999999;

    // Directed: first snapshot opens a slot, bar change emits, same bar only updates.
    push_req(snap_req(0, 93000000, '0));
    push_req(snap_req(0, 93059999, 32'hFFFF_FFFF));
    push_req(snap_req(0, 93100000, 32'h1234_5678));
    push_req(snap_req(999999, 92959999, 32'hAAAA_AAAA));
    push_req(snap_req(999999, 113000000, 32'h5555_5555));
    push_req(snap_req(999999, 130000000, 32'hFFFF_FFFF));
    push_req(snap_req(999999, 149999999, 32'h0));
    push_req(flush_req(0));
    push_req(flush_req(1));
    push_req(flush_req(1023));
    push_req(flush_req(2));
    random_phase(144);

    // Widest sessions with the 30 s grid; late times land past the last grid point.
    set_sessions(0, 120000000, 120000000, 235959999, STEP_30S);
    push_req(snap_req(0, 150100000, 32'h1));
    push_req(snap_req(0, 235959999, 32'h2));
    push_req(snap_req(0, 0, 32'h3));
    push_req(flush_req(0));
    random_phase(144);

    push_cfg(REG_STEP_MODE, TIME_W'(STEP_300S));
    push_req(snap_req(999999, 150459999, 32'h4));
    push_req(snap_req(999999, 150500000, 32'h5));
    push_req(flush_req(1));
    random_phase(144);

    // Unknown step mode behaves as the one-minute grid.
    push_cfg(REG_STEP_MODE, TIME_W'(2'd3));
    random_phase(144);

    set_sessions(235959999, 0, 0, 235959999, STEP_60S);
    random_phase(144);

    // Fill the table, then hit it with new codes and flushes.
    set_sessions(93000000, 113000000, 130000000, 150000000, STEP_60S);
    for (int i = 0; i < TABLE_SLOTS + 4; i++)
      push_req(snap_req(500000 + i, 93000000 + $urandom_range(0, 999999), $urandom));
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 1) == 0)
        push_req(snap_req(600000 + i, 100000000, $urandom));
      else
        push_req(flush_req($urandom_range(0, 1023)));
    end
    push_req(flush_req(1023));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!all_done && !timed_out) @(posedge clk_i);
    if (timed_out) begin
      $display("FAIL");
      $finish;
    end else begin
      if (errors == 0)
        $display("PASS");
      else
        $display("FAIL");
      $finish;
    end
  end
endmodule
